FILE: sv/ghtc_pkg.sv
package ghtc_pkg;

    localparam int FRAME_TAIL_DEF = 10;
    localparam logic [7:0] HDR_BYTE = 8'h55;
    localparam logic [7:0] GYRO_TYPE = 8'h52;
    localparam logic [22:0] OUT_MAX = 23'h7f_ffff;
    localparam logic [31:0] ONE30 = 32'h4000_0000;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_W = 24;

    localparam logic [31:0] RATE_GAIN_RST = 32'd2621440;
    localparam logic [16:0] SMOOTH_GAIN_RST = 17'd65536;
    localparam logic [15:0] CURVE_RST = 16'd4096;
    localparam logic [15:0] HEAD_TARGET_RST = 16'd5120;
    localparam logic [15:0] VIEW_TARGET_RST = 16'd23040;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_GAIN   = 3'd0,
        CFG_SMOOTH_GAIN = 3'd1,
        CFG_ROLL_CURVE  = 3'd2,
        CFG_YAW_CURVE   = 3'd3,
        CFG_HEAD_TARGET = 3'd4,
        CFG_VIEW_TARGET = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0] rate_gain;
        logic [16:0] smooth_gain;
        logic [15:0] roll_curve;
        logic [15:0] yaw_curve;
        logic [15:0] head_target;
        logic [15:0] view_target;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] roll_rate;
        logic signed [15:0] yaw_rate;
        logic               recenter;
    } rate_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LN_NORM,
        ST_LN_SQ,
        ST_LN_UPD,
        ST_INT_MUL,
        ST_INT_ADD,
        ST_SM_MUL,
        ST_SM_ADD,
        ST_MAP,
        ST_L_MUL,
        ST_L_UPD,
        ST_EX_MUL,
        ST_EX_UPD,
        ST_V_MUL,
        ST_V_SHIFT,
        ST_DONE
    } back_state_t;

    typedef logic [31:0] root_tab_t [16];

    function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
        if (x > 52'sd2147483647) return 32'sh7fff_ffff;
        if (x < -52'sd2147483648) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v = v_in;
        res = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (b > v) b = b >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    // successive square roots of 2.0, Q2.30
    function automatic root_tab_t exp2_roots();
        root_tab_t tab;
        logic [63:0] root;
        root = 64'h8000_0000;
        for (int k = 0; k < 16; k++) begin
            root = isqrt64(root << 30);
            tab[k] = root[31:0];
        end
        return tab;
    endfunction

endpackage

FILE: sv/ghtc_front.sv
module ghtc_front #(
    parameter int FRAME_TAIL = ghtc_pkg::FRAME_TAIL_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  q_full,
    output logic                  q_push,
    output ghtc_pkg::rate_req_t   q_req
);
    import ghtc_pkg::*;

    localparam int POS_W = $clog2(FRAME_TAIL + 1);
    localparam int IDX_W = $clog2(FRAME_TAIL);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             pend_reg, pend_next;
    logic [7:0]       bytes_reg [FRAME_TAIL];
    logic [POS_W-1:0] idx_full;
    logic             accept;
    logic             store;

    assign s_tready = !q_full;
    assign accept = s_tvalid && s_tready;
    assign idx_full = pos_reg - POS_W'(1);

    assign q_req.roll_rate = {bytes_reg[2], bytes_reg[1]};
    assign q_req.yaw_rate = {bytes_reg[6], bytes_reg[5]};
    assign q_req.recenter = pend_reg;

    always_comb begin
        pos_next = pos_reg;
        pend_next = pend_reg;
        q_push = 1'b0;
        store = 1'b0;
        if (accept) begin
            if (s_tuser[0]) begin
                pend_next = 1'b1;
            end else if (pos_reg == '0) begin
                if (s_tdata == HDR_BYTE) pos_next = POS_W'(1);
            end else begin
                store = 1'b1;
                if (pos_reg == POS_W'(FRAME_TAIL)) begin
                    pos_next = '0;
                    if (bytes_reg[0] == GYRO_TYPE) begin
                        q_push = 1'b1;
                        pend_next = 1'b0;
                    end
                end else begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            pend_reg <= 1'b1;
        end else begin
            pos_reg <= pos_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store) bytes_reg[idx_full[IDX_W-1:0]] <= s_tdata;
    end

endmodule

FILE: sv/ghtc_fifo.sv
module ghtc_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ghtc_pkg::rate_req_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output ghtc_pkg::rate_req_t pop_data
);
    import ghtc_pkg::*;

    rate_req_t   mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push && !full) begin
            wr_ptr_next = !wr_ptr_reg;
            count_next = count_next + 2'd1;
        end
        if (pop && !empty) begin
            rd_ptr_next = !rd_ptr_reg;
            count_next = count_next - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: sv/ghtc_back.sv
module ghtc_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ghtc_pkg::cfg_t             cfg,
    input  logic                       q_empty,
    input  ghtc_pkg::rate_req_t        q_data,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [2*ghtc_pkg::OUT_W-1:0] m_tdata
);
    import ghtc_pkg::*;

    localparam root_tab_t ROOTS = exp2_roots();

    back_state_t        state_reg, state_next;
    logic               ch_reg, ch_next;
    logic               lg_sel_reg, lg_sel_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic signed [15:0] rate_reg [2];
    logic signed [15:0] rate_next [2];
    logic               rc_reg, rc_next;
    logic signed [31:0] angle_reg [2];
    logic signed [31:0] angle_next [2];
    logic signed [31:0] smooth_reg [2];
    logic signed [31:0] smooth_next [2];
    logic [20:0]        lh_reg, lh_next;
    logic [31:0]        lv_reg, lv_next;
    logic [4:0]         lp_reg, lp_next;
    logic [30:0]        lm_reg, lm_next;
    logic [15:0]        lfr_reg, lfr_next;
    logic signed [12:0] eint_reg, eint_next;
    logic [15:0]        efrac_reg, efrac_next;
    logic [31:0]        r_reg, r_next;
    logic [22:0]        mag_reg [2];
    logic [22:0]        mag_next [2];
    logic               out_valid_reg, out_valid_next;
    logic [2*OUT_W-1:0] out_data_reg, out_data_next;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod_reg;

    logic [15:0]        curve;
    logic [19:0]        view_v;
    logic signed [32:0] diff;
    logic signed [22:0] lval;
    logic signed [31:0] s_cur;
    logic [31:0]        abs_s;

    assign curve = ch_reg ? cfg.yaw_curve : cfg.roll_curve;
    assign view_v = {cfg.view_target, 4'b0};
    assign diff = 33'(angle_reg[ch_reg]) - 33'(smooth_reg[ch_reg]);
    assign lval = $signed({2'b0, lp_reg, lfr_reg}) - $signed({2'b0, lh_reg}) - 23'sd786432;
    assign s_cur = smooth_reg[ch_reg];
    assign abs_s = s_cur[31] ? 32'(-33'(s_cur)) : s_cur;

    assign q_pop = (state_reg == ST_IDLE) && !q_empty;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_INT_MUL: begin
                mul_a = 34'(rate_reg[ch_reg]);
                mul_b = $signed({2'b0, cfg.rate_gain});
            end
            ST_SM_MUL: begin
                mul_a = 34'(diff);
                mul_b = $signed({17'b0, cfg.smooth_gain});
            end
            ST_LN_SQ: begin
                mul_a = $signed({3'b0, lm_reg});
                mul_b = $signed({3'b0, lm_reg});
            end
            ST_L_MUL: begin
                mul_a = 34'(lval);
                mul_b = $signed({18'b0, curve});
            end
            ST_EX_MUL: begin
                mul_a = $signed({2'b0, r_reg});
                mul_b = $signed({2'b0, ROOTS[cnt_reg]});
            end
            ST_V_MUL: begin
                mul_a = $signed({14'b0, view_v});
                mul_b = $signed({2'b0, r_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_comb begin
        logic [31:0]        sq;
        logic signed [51:0] rnd;
        logic signed [51:0] sum;
        logic [50:0]        vm;
        logic signed [13:0] sh;
        logic [13:0]        nsh;
        logic [73:0]        wide;
        logic [50:0]        shr;
        logic [23:0]        res0, res1;

        state_next = state_reg;
        ch_next = ch_reg;
        lg_sel_next = lg_sel_reg;
        cnt_next = cnt_reg;
        rate_next = rate_reg;
        rc_next = rc_reg;
        angle_next = angle_reg;
        smooth_next = smooth_reg;
        lh_next = lh_reg;
        lv_next = lv_reg;
        lp_next = lp_reg;
        lm_next = lm_reg;
        lfr_next = lfr_reg;
        eint_next = eint_reg;
        efrac_next = efrac_reg;
        r_next = r_reg;
        mag_next = mag_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next = out_data_reg;

        sq = prod_reg[61:30];
        rnd = '0;
        sum = '0;
        vm = prod_reg[50:0];
        sh = 14'(eint_reg) - 14'sd30;
        nsh = 14'(-sh);
        wide = 74'(vm) << sh[4:0];
        shr = vm >> nsh[5:0];
        res0 = smooth_reg[0][31] ? {1'b0, mag_reg[0]} : 24'(-$signed({1'b0, mag_reg[0]}));
        res1 = smooth_reg[1][31] ? {1'b0, mag_reg[1]} : 24'(-$signed({1'b0, mag_reg[1]}));

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    rate_next[0] = q_data.roll_rate;
                    rate_next[1] = q_data.yaw_rate;
                    rc_next = q_data.recenter;
                    lv_next = (cfg.head_target == '0) ? 32'd1 : {16'b0, cfg.head_target};
                    lp_next = 5'd31;
                    lg_sel_next = 1'b0;
                    state_next = ST_LN_NORM;
                end
            end
            ST_LN_NORM: begin
                if (lv_reg[31]) begin
                    lm_next = lv_reg[31:1];
                    lfr_next = '0;
                    cnt_next = '0;
                    state_next = ST_LN_SQ;
                end else begin
                    lv_next = lv_reg << 1;
                    lp_next = lp_reg - 5'd1;
                end
            end
            ST_LN_SQ: state_next = ST_LN_UPD;
            ST_LN_UPD: begin
                if (sq[31]) begin
                    lm_next = sq[31:1];
                    lfr_next = {lfr_reg[14:0], 1'b1};
                end else begin
                    lm_next = sq[30:0];
                    lfr_next = {lfr_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    if (!lg_sel_reg) begin
                        lh_next = {lp_reg, lfr_next};
                        ch_next = 1'b0;
                        state_next = ST_INT_MUL;
                    end else begin
                        state_next = ST_L_MUL;
                    end
                end else begin
                    state_next = ST_LN_SQ;
                end
            end
            ST_INT_MUL: state_next = ST_INT_ADD;
            ST_INT_ADD: begin
                rnd = prod_reg[51:0] + 52'sd2048;
                sum = 52'(angle_reg[ch_reg]) + (rnd >>> 12);
                angle_next[ch_reg] = sat32(sum);
                if (!ch_reg) begin
                    ch_next = 1'b1;
                    state_next = ST_INT_MUL;
                end else begin
                    if (rc_reg) begin
                        angle_next[0] = '0;
                        angle_next[1] = '0;
                        rc_next = 1'b0;
                    end
                    ch_next = 1'b0;
                    state_next = ST_SM_MUL;
                end
            end
            ST_SM_MUL: state_next = ST_SM_ADD;
            ST_SM_ADD: begin
                rnd = prod_reg[51:0] + 52'sd32768;
                sum = 52'(smooth_reg[ch_reg]) + (rnd >>> 16);
                smooth_next[ch_reg] = sat32(sum);
                state_next = ST_MAP;
            end
            ST_MAP: begin
                if (curve == '0) begin
                    mag_next[ch_reg] = 23'(view_v);
                    state_next = ST_DONE;
                end else if (abs_s == '0) begin
                    mag_next[ch_reg] = '0;
                    state_next = ST_DONE;
                end else begin
                    lv_next = abs_s;
                    lp_next = 5'd31;
                    lg_sel_next = 1'b1;
                    state_next = ST_LN_NORM;
                end
                if (state_next == ST_DONE && !ch_reg) begin
                    ch_next = 1'b1;
                    state_next = ST_SM_MUL;
                end
            end
            ST_L_MUL: state_next = ST_L_UPD;
            ST_L_UPD: begin
                eint_next = prod_reg[40:28];
                efrac_next = prod_reg[27:12];
                r_next = ONE30;
                cnt_next = '0;
                state_next = ST_EX_MUL;
            end
            ST_EX_MUL: state_next = ST_EX_UPD;
            ST_EX_UPD: begin
                if (efrac_reg[15]) r_next = sq;
                efrac_next = {efrac_reg[14:0], 1'b0};
                cnt_next = cnt_reg + 4'd1;
                state_next = (cnt_reg == 4'd15) ? ST_V_MUL : ST_EX_MUL;
            end
            ST_V_MUL: state_next = ST_V_SHIFT;
            ST_V_SHIFT: begin
                if (vm == '0) begin
                    mag_next[ch_reg] = '0;
                end else if (!sh[13]) begin
                    if (sh > 14'sd23) mag_next[ch_reg] = OUT_MAX;
                    else if (wide > 74'(OUT_MAX)) mag_next[ch_reg] = OUT_MAX;
                    else mag_next[ch_reg] = wide[22:0];
                end else begin
                    if (nsh >= 14'd51) mag_next[ch_reg] = '0;
                    else if (shr > 51'(OUT_MAX)) mag_next[ch_reg] = OUT_MAX;
                    else mag_next[ch_reg] = shr[22:0];
                end
                if (!ch_reg) begin
                    ch_next = 1'b1;
                    state_next = ST_SM_MUL;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next = {res1, res0};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            angle_reg[0] <= '0;
            angle_reg[1] <= '0;
            smooth_reg[0] <= '0;
            smooth_reg[1] <= '0;
            ch_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            angle_reg <= angle_next;
            smooth_reg <= smooth_next;
            ch_reg <= ch_next;
        end
    end

    always_ff @(posedge aclk) begin
        lg_sel_reg <= lg_sel_next;
        cnt_reg <= cnt_next;
        rate_reg <= rate_next;
        rc_reg <= rc_next;
        lh_reg <= lh_next;
        lv_reg <= lv_next;
        lp_reg <= lp_next;
        lm_reg <= lm_next;
        lfr_reg <= lfr_next;
        eint_reg <= eint_next;
        efrac_reg <= efrac_next;
        r_reg <= r_next;
        mag_reg <= mag_next;
        out_data_reg <= out_data_next;
    end

endmodule

FILE: sv/gyro_head_tracker_curve.sv
// Gyro head tracker: takes IMU serial bytes (or recenter requests) on the s_ side, one per
// cycle into the frame parser while the queue is not full, and for every gyro frame returns
// a pitch/yaw view command on the m_ side. Each gyro frame is then worked out by a sequencer
// around one shared 34x34 multiplier: a log2 of head_target, two integrations, and per
// channel a smoothing step, a normalize, 16 squaring steps for log2, 16 root products for
// exp2 and a final scale. A channel skips the power when its curve or its smoothed angle is
// zero, and a result stall holds the sequencer; this unit sets the frame throughput.
// Bytes keep flowing while a frame is computed, until the two-entry queue between the parser
// and the sequencer fills; an output register holds each result until it is taken.
// Config writes belong to idle periods only.
module gyro_head_tracker_curve #(
    parameter int FRAME_TAIL = ghtc_pkg::FRAME_TAIL_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // rx_byte
    input  logic [0:0]                          s_tuser,   // kind
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [2*ghtc_pkg::OUT_W-1:0]        m_tdata,   // view_pitch, view_yaw
    input  logic                                cfg_wen,
    input  logic [ghtc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ghtc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import ghtc_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      q_full, q_empty, q_push, q_pop;
    rate_req_t q_in, q_out;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wen) begin
            unique case (cfg_index)
                CFG_RATE_GAIN:   cfg_next.rate_gain = cfg_wdata;
                CFG_SMOOTH_GAIN: cfg_next.smooth_gain = cfg_wdata[16:0];
                CFG_ROLL_CURVE:  cfg_next.roll_curve = cfg_wdata[15:0];
                CFG_YAW_CURVE:   cfg_next.yaw_curve = cfg_wdata[15:0];
                CFG_HEAD_TARGET: cfg_next.head_target = cfg_wdata[15:0];
                CFG_VIEW_TARGET: cfg_next.view_target = cfg_wdata[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rate_gain <= RATE_GAIN_RST;
            cfg_reg.smooth_gain <= SMOOTH_GAIN_RST;
            cfg_reg.roll_curve <= CURVE_RST;
            cfg_reg.yaw_curve <= CURVE_RST;
            cfg_reg.head_target <= HEAD_TARGET_RST;
            cfg_reg.view_target <= VIEW_TARGET_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ghtc_front #(.FRAME_TAIL(FRAME_TAIL)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_req    (q_in)
    );

    ghtc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_out)
    );

    ghtc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: sv/ghtc_checker.sv
module ghtc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // results stay until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // output register comes out of reset empty
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // magnitudes saturate symmetrically
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23:0] != 24'h800000) && (m_tdata[47:24] != 24'h800000))
        else $error("view output at most negative code");

endmodule

bind gyro_head_tracker_curve ghtc_checker u_ghtc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
